/* hw/rtl/hsfd_pkg.sv */
// Shared types and constants of the humidity sensor frame decoder.
package hsfd_pkg;

  typedef logic [23:0]        frame_t;
  typedef logic signed [14:0] centi_t;
  typedef logic signed [10:0] coeff_t;
  typedef logic [1:0]         status_t;
  typedef logic               cfg_index_t;
  typedef logic [14:0]        cfg_data_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_ERR  = 2'd1,
    STATUS_KIND_ERR = 2'd2
  } status_e;

  // Configuration register indexes
  localparam cfg_index_t CFG_COMP_COEFF = 1'b0;
  localparam cfg_index_t CFG_REF_TEMP   = 1'b1;

  localparam coeff_t COEFF_RESET    = -11'sd150;
  localparam centi_t REF_TEMP_RESET = 15'sd2500;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // Request kinds, also the value of status bit 1
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
  localparam logic [14:0]        HUM_SCALE   = 15'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
  localparam logic signed [15:0] HUM_OFFSET  = -16'sd600;

  // floor(x / 1000) = (x * ceil(2^36 / 1000)) >> 36, exact for x < 2^26
  localparam logic [26:0] RECIP_1000  = 27'd68719477;
  localparam int          RECIP_SHIFT = 36;

  localparam logic signed [17:0] OUT_MAX = 18'sd16383;
  localparam logic signed [17:0] OUT_MIN = -18'sd16384;

endpackage

/* hw/rtl/hsfd_ifs.sv */
// Channel interfaces of the humidity sensor frame decoder.
interface hsfd_frame_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  hsfd_pkg::frame_t      raw_frame;

  modport source (output valid, output req_type, output raw_frame, input ready);
  modport sink   (input valid, input req_type, input raw_frame, output ready);
endinterface

interface hsfd_result_if;
  logic                  valid;
  logic                  ready;
  hsfd_pkg::status_t     status;
  hsfd_pkg::centi_t      value_centi;
  hsfd_pkg::centi_t      compensated_centi;
  logic                  comp_valid;

  modport source (output valid, output status, output value_centi,
                  output compensated_centi, output comp_valid, input ready);
  modport sink   (input valid, input status, input value_centi,
                  input compensated_centi, input comp_valid, output ready);
endinterface

interface hsfd_cfg_if;
  logic                  valid;
  logic                  ready;
  hsfd_pkg::cfg_index_t  index;
  hsfd_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/humidity_sensor_frame_decoder.sv */
// Top level: CRC check, conversion and humidity compensation of sensor frames.
//
//   channel   | dir | carries                                         | handshake
//   ----------+-----+-------------------------------------------------+-----------
//   frame_i   | in  | req_type, raw_frame                             | valid/ready
//   result_o  | out | status, value_centi, compensated_centi, comp_valid | valid/ready
//   cfg_i     | in  | index, data (register write)                    | valid/ready
//
// One frame per cycle is taken while no held result stalls the pipe; result_o.valid rises once
// the frame has passed the input register, three pipeline stages and the output register.
// The latency is set by the chain of two multiplications on the compensation path:
// coefficient times temperature difference, then the reciprocal of 1000.
// All stages advance together; a held result stalls the whole pipe and drops
// frame_i.ready in the same cycle. cfg_i is always ready.
// Reset clears the pipe, the stored temperature and restores the register defaults.
module humidity_sensor_frame_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsfd_frame_if.sink           frame_i,
  hsfd_result_if.source        result_o,
  hsfd_cfg_if.sink             cfg_i
);

  // Advance every stage when the output register is free or being emptied
  logic advance;
  assign advance = !result_o.valid || result_o.ready;
  assign frame_i.ready = advance;
  assign cfg_i.ready   = 1'b1;

  // ---------------------------------------------------------------- config
  hsfd_pkg::coeff_t coeff_q;
  hsfd_pkg::centi_t ref_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q    <= hsfd_pkg::COEFF_RESET;
      ref_temp_q <= hsfd_pkg::REF_TEMP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        hsfd_pkg::CFG_COMP_COEFF: coeff_q    <= cfg_i.data[10:0];
        hsfd_pkg::CFG_REF_TEMP:   ref_temp_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Input register
  logic             s1_valid_q;
  logic             s1_req_q;
  hsfd_pkg::frame_t s1_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_req_q   <= frame_i.req_type;
      s1_frame_q <= frame_i.raw_frame;
    end
  end

  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in);
    logic [7:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ hsfd_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]        s1_crc;
  logic [15:0]       s1_reading;
  logic [14:0]       s1_scale;
  logic [30:0]       s1_scaled;
  logic signed [15:0] s1_offset;
  logic signed [15:0] s1_conv;
  hsfd_pkg::status_e s1_status;
  logic              s1_temp_ok;

  always_comb begin
    s1_crc     = crc8_byte(crc8_byte(s1_frame_q[23:16]) ^ s1_frame_q[15:8]);
    s1_reading = {s1_frame_q[23:10], 2'b00};
    s1_scale   = (s1_req_q == hsfd_pkg::KIND_HUM) ? hsfd_pkg::HUM_SCALE
                                                  : hsfd_pkg::TEMP_SCALE;
    s1_offset  = (s1_req_q == hsfd_pkg::KIND_HUM) ? hsfd_pkg::HUM_OFFSET
                                                  : hsfd_pkg::TEMP_OFFSET;
    s1_scaled  = 31'(s1_scale) * 31'(s1_reading);
    s1_conv    = s1_offset + $signed({1'b0, s1_scaled[30:16]});
    // CRC failure wins over a kind mismatch
    priority if (s1_crc != s1_frame_q[7:0]) begin
      s1_status = hsfd_pkg::STATUS_CRC_ERR;
    end else if (s1_frame_q[9] != s1_req_q) begin
      s1_status = hsfd_pkg::STATUS_KIND_ERR;
    end else begin
      s1_status = hsfd_pkg::STATUS_OK;
    end
    s1_temp_ok = (s1_status == hsfd_pkg::STATUS_OK) && (s1_req_q == hsfd_pkg::KIND_TEMP);
  end

  // Last good temperature; updated as its frame leaves stage 1
  hsfd_pkg::centi_t last_temp_q;
  logic             temp_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q <= '0;
      temp_seen_q <= 1'b0;
    end else if (advance && s1_valid_q && s1_temp_ok) begin
      last_temp_q <= s1_conv[14:0];
      temp_seen_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 2
  typedef struct packed {
    hsfd_pkg::status_e status;
    hsfd_pkg::centi_t  value;
    logic              hum_ok;
  } item_t;

  logic  s2_valid_q;
  item_t s2_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_item_q.status <= s1_status;
      s2_item_q.value  <= (s1_status == hsfd_pkg::STATUS_OK) ? s1_conv[14:0] : '0;
      s2_item_q.hum_ok <= (s1_status == hsfd_pkg::STATUS_OK) &&
                          (s1_req_q == hsfd_pkg::KIND_HUM);
    end
  end

  // Temperature difference times coefficient, then split into sign and magnitude
  logic signed [15:0] s2_diff;
  logic signed [26:0] s2_prod;
  logic [25:0]        s2_mag;

  always_comb begin
    s2_diff = {ref_temp_q[14], ref_temp_q} - {last_temp_q[14], last_temp_q};
    s2_prod = $signed({{11{s2_diff[15]}}, s2_diff}) *
              $signed({{16{coeff_q[10]}}, coeff_q});
    s2_mag  = s2_prod[26] ? 26'(-s2_prod) : s2_prod[25:0];
  end

  // ---------------------------------------------------------------- stage 3
  logic        s3_valid_q;
  item_t       s3_item_q;
  logic        s3_comp_en_q;
  logic        s3_neg_q;
  logic [25:0] s3_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_item_q    <= s2_item_q;
      s3_comp_en_q <= s2_item_q.hum_ok && temp_seen_q;
      s3_neg_q     <= s2_prod[26];
      s3_mag_q     <= s2_mag;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic        s4_valid_q;
  item_t       s4_item_q;
  logic        s4_comp_en_q;
  logic        s4_neg_q;
  logic [52:0] s4_recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_item_q    <= s3_item_q;
      s4_comp_en_q <= s3_comp_en_q;
      s4_neg_q     <= s3_neg_q;
      s4_recip_q   <= 53'(s3_mag_q) * 53'(hsfd_pkg::RECIP_1000);
    end
  end

  // Truncated quotient, sign restored, added and clamped to 15 bits
  logic [15:0]        s4_quot;
  logic signed [16:0] s4_delta;
  logic signed [17:0] s4_sum;
  hsfd_pkg::centi_t   s4_comp;

  always_comb begin
    s4_quot  = s4_recip_q[hsfd_pkg::RECIP_SHIFT +: 16];
    s4_delta = s4_neg_q ? -$signed({1'b0, s4_quot}) : $signed({1'b0, s4_quot});
    s4_sum   = {{3{s4_item_q.value[14]}}, s4_item_q.value} +
               {s4_delta[16], s4_delta};
    priority if (s4_sum > hsfd_pkg::OUT_MAX) begin
      s4_comp = hsfd_pkg::OUT_MAX[14:0];
    end else if (s4_sum < hsfd_pkg::OUT_MIN) begin
      s4_comp = hsfd_pkg::OUT_MIN[14:0];
    end else begin
      s4_comp = s4_sum[14:0];
    end
  end

  // ---------------------------------------------------------------- output
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_o.status            <= s4_item_q.status;
      result_o.value_centi       <= s4_item_q.value;
      result_o.compensated_centi <= s4_comp_en_q ? s4_comp : '0;
      result_o.comp_valid        <= s4_comp_en_q;
    end
  end

  assign result_o.valid = out_valid_q;

  // ---------------------------------------------------------------- checks
  a_temp_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && s1_temp_ok |=> temp_seen_q)
    else $error("good temperature not recorded");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !frame_i.ready)
    else $error("input taken while result held");

  a_comp_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.comp_valid |->
      result_o.status == hsfd_pkg::STATUS_OK && temp_seen_q)
    else $error("compensation flagged without good humidity and temperature");

endmodule
